// File: hw/rtl/crsrd_pkg.sv
// ----------------------------------------------------------------------------
// crsrd_pkg
// Shared widths, types and helpers of the current reference soft ramp-down.
// ----------------------------------------------------------------------------
package crsrd_pkg;

	localparam int CUR_W      = 16;
	localparam int ANGLE_W    = 16;
	localparam int TICK_W     = 16;
	localparam int DIV_CNT_W  = $clog2(CUR_W);
	localparam logic [TICK_W-1:0] RAMP_TICKS_RST = TICK_W'(1000);

	typedef logic signed [CUR_W-1:0] cur_t;
	typedef logic [CUR_W-1:0]        mag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_D,
		ST_DIV_Q
	} state_t;

	// Magnitude of a current; the most negative code maps to its true size.
	function automatic mag_t abs_cur(input cur_t x);
		mag_t r;
		r = x[CUR_W-1] ? mag_t'(-x) : mag_t'(x);
		return r;
	endfunction

	// Move a current one step toward zero, snapping when within one step.
	function automatic cur_t approach_zero(input cur_t cur, input mag_t step);
		mag_t a;
		cur_t r;
		a = abs_cur(cur);
		if (a <= step) begin
			r = '0;
		end else if (cur[CUR_W-1]) begin
			r = cur_t'(cur + cur_t'(step));
		end else begin
			r = cur_t'(cur - cur_t'(step));
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/current_reference_soft_ramp_down_top.sv
// ----------------------------------------------------------------------------
// current_reference_soft_ramp_down_top
// Soft ramp-down of the d/q current references, one word per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one tick: start_request,
//   id_ref_in, iq_ref_in, angle_in. Output channel (out_valid/out_stall)
//   returns one word per tick: id_ref_out, iq_ref_out, angle_out.
//   The ramp_ticks register is written on cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is high only while no step computation runs.
// Output: the result is offered in the cycle after the input word is taken.
// Pacing: a ramp tick (start_request high) leaves the input free for the next
//   word. A pass-through tick computes both per-tick steps on one shared
//   bit-serial divider, d axis then q axis, and no new word is taken until
//   both steps are done.
// Reset: held currents, angle and steps clear to zero, ramp_ticks to 1000.
// Stall: while out_stall holds a pending result, the result stays put and
//   no new input word is taken.
// ----------------------------------------------------------------------------
module current_reference_soft_ramp_down_top import crsrd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [TICK_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                start_request,
	input  cur_t                id_ref_in,
	input  cur_t                iq_ref_in,
	input  logic [ANGLE_W-1:0]  angle_in,
	output logic                out_valid,
	input  logic                out_stall,
	output cur_t                id_ref_out,
	output cur_t                iq_ref_out,
	output logic [ANGLE_W-1:0]  angle_out
);

	state_t             state_q, state_d;
	logic [TICK_W-1:0]  ramp_ticks_q;
	cur_t               id_hold_q, iq_hold_q;
	logic [ANGLE_W-1:0] angle_hold_q;
	mag_t               d_step_q, q_step_q;
	logic               out_valid_q;

	logic               in_acc;
	logic               div_start;
	mag_t               div_dividend;
	logic [TICK_W-1:0]  div_divisor;
	logic               div_done;
	mag_t               div_quo;
	mag_t               step_fixed;

	assign in_acc      = in_valid && !in_stall;
	assign div_divisor = (ramp_ticks_q == '0) ? TICK_W'(1) : ramp_ticks_q;

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = abs_cur(id_ref_in);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && !start_request) begin
					div_start = 1'b1;
					state_d   = ST_DIV_D;
				end
			end
			ST_DIV_D: begin
				div_dividend = abs_cur(iq_hold_q);
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV_Q;
				end
			end
			ST_DIV_Q: begin
				div_dividend = abs_cur(iq_hold_q);
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a truncated-to-zero step on a nonzero current becomes one LSB
	always_comb begin
		step_fixed = div_quo;
		if (div_quo == '0) begin
			if ((state_q == ST_DIV_D && id_hold_q != '0) ||
			    (state_q == ST_DIV_Q && iq_hold_q != '0)) begin
				step_fixed = mag_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_ticks_q <= RAMP_TICKS_RST;
			id_hold_q    <= '0;
			iq_hold_q    <= '0;
			angle_hold_q <= '0;
			d_step_q     <= '0;
			q_step_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ramp_ticks_q <= cfg_data;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				if (start_request) begin
					// bring Iq down first, then Id
					if (iq_hold_q != '0) begin
						iq_hold_q <= approach_zero(iq_hold_q, q_step_q);
					end else begin
						id_hold_q <= approach_zero(id_hold_q, d_step_q);
					end
				end else begin
					id_hold_q    <= id_ref_in;
					iq_hold_q    <= iq_ref_in;
					angle_hold_q <= angle_in;
				end
			end
			if (div_done && state_q == ST_DIV_D) begin
				d_step_q <= step_fixed;
			end
			if (div_done && state_q == ST_DIV_Q) begin
				q_step_q <= step_fixed;
			end
		end
	end

	crsrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_stall   = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign cfg_ready  = state_q == ST_IDLE;
	assign out_valid  = out_valid_q;
	assign id_ref_out = id_hold_q;
	assign iq_ref_out = iq_hold_q;
	assign angle_out  = angle_hold_q;

endmodule

// File: hw/rtl/crsrd_div.sv
// ----------------------------------------------------------------------------
// crsrd_div
// Bit-serial restoring divider: one quotient bit per cycle, shifted into the
// register that starts out holding the dividend.
// ----------------------------------------------------------------------------
module crsrd_div import crsrd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mag_t              dividend,
	input  logic [TICK_W-1:0] divisor,
	output logic              done,
	output mag_t              quotient
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TICK_W-1:0]    rem_q;
	logic [TICK_W-1:0]    dvs_q;
	mag_t                 quo_q;

	logic [TICK_W:0] trial;
	logic [TICK_W:0] diff;
	logic            fits;
	logic            last;

	always_comb begin
		trial = {rem_q, quo_q[CUR_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
		last  = cnt_q == DIV_CNT_W'(CUR_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			// restore by keeping the trial when the divisor does not fit
			rem_q <= fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
			quo_q <= {quo_q[CUR_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/crsrd_chk.sv
// ----------------------------------------------------------------------------
// crsrd_chk
// Port-level checks of the soft ramp-down block, bound to its top level.
// ----------------------------------------------------------------------------
module crsrd_chk import crsrd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               start_request,
	input cur_t               id_ref_in,
	input cur_t               iq_ref_in,
	input logic [ANGLE_W-1:0] angle_in,
	input logic               out_valid,
	input logic               out_stall,
	input cur_t               id_ref_out,
	input cur_t               iq_ref_out,
	input logic [ANGLE_W-1:0] angle_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(id_ref_out) && $stable(iq_ref_out) &&
			$stable(angle_out))
		else $error("stalled result changed");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("no result after accepted word");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !start_request |=>
			id_ref_out == $past(id_ref_in) && iq_ref_out == $past(iq_ref_in) &&
			angle_out == $past(angle_in))
		else $error("pass-through tick mismatch");

	a_angle_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && start_request |=> $stable(angle_out))
		else $error("angle moved during ramp");

endmodule

bind current_reference_soft_ramp_down_top crsrd_chk u_crsrd_chk (.*);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the d/q current reference soft ramp-down.
// A driver and a monitor run on their own clocked blocks, with random gaps
// and stalls. Expected words are worked out tick by tick from the held
// currents, steps and angle. The ramp count register is swept through zero,
// one, small counts, the reset value and the largest count.
// ----------------------------------------------------------------------------
module tb import crsrd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GAP_MAX      = 12;
	localparam int SETTLE_TICKS = 2 * CUR_W + 8;
	localparam int IDLE_LIMIT   = 1000;
	localparam int PHASE_ITEMS  = 64;

	typedef struct packed {
		logic               req;
		cur_t               id;
		cur_t               iq;
		logic [ANGLE_W-1:0] angle;
	} ramp_tick_t;

	typedef struct packed {
		cur_t               id;
		cur_t               iq;
		logic [ANGLE_W-1:0] angle;
	} dq_ref_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [TICK_W-1:0]  cfg_data      = '0;
	logic               in_valid      = 1'b0;
	logic               in_stall;
	logic               start_request = 1'b0;
	cur_t               id_ref_in     = '0;
	cur_t               iq_ref_in     = '0;
	logic [ANGLE_W-1:0] angle_in      = '0;
	logic               out_valid;
	logic               out_stall     = 1'b0;
	cur_t               id_ref_out;
	cur_t               iq_ref_out;
	logic [ANGLE_W-1:0] angle_out;

	current_reference_soft_ramp_down_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_request (start_request),
		.id_ref_in     (id_ref_in),
		.iq_ref_in     (iq_ref_in),
		.angle_in      (angle_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.id_ref_out    (id_ref_out),
		.iq_ref_out    (iq_ref_out),
		.angle_out     (angle_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [TICK_W-1:0]  ramp_ticks_cfg = RAMP_TICKS_RST;
	int                 id_held        = 0;
	int                 iq_held        = 0;
	int                 d_step_held    = 0;
	int                 q_step_held    = 0;
	logic [ANGLE_W-1:0] angle_held     = '0;

	ramp_tick_t tick_pending[$];
	dq_ref_t    dq_expected[$];
	int         ticks_in_flight = 0;
	int         fail_cnt        = 0;
	bit         drv_burst       = 1'b0;
	bit         mon_burst       = 1'b0;

	function automatic int per_tick_step(int cur, int n);
		int s;
		s = cur / n;
		if (s == 0 && cur != 0)
			s = (cur > 0) ? 1 : -1;
		return s;
	endfunction

	function automatic int toward_zero(int cur, int step);
		int mag;
		mag = (step < 0) ? -step : step;
		if (cur > 0)
			return (cur <= mag) ? 0 : cur - mag;
		if (cur < 0)
			return (-cur <= mag) ? 0 : cur + mag;
		return 0;
	endfunction

	function dq_ref_t ramp_predict(ramp_tick_t t);
		int      n;
		dq_ref_t r;
		if (t.req) begin
			// q axis first, d axis only once q is down
			if (iq_held != 0)
				iq_held = toward_zero(iq_held, q_step_held);
			else
				id_held = toward_zero(id_held, d_step_held);
		end else begin
			n = (ramp_ticks_cfg == 0) ? 1 : int'(ramp_ticks_cfg);
			id_held     = int'($signed(t.id));
			iq_held     = int'($signed(t.iq));
			angle_held  = t.angle;
			d_step_held = per_tick_step(id_held, n);
			q_step_held = per_tick_step(iq_held, n);
		end
		r.id    = cur_t'(id_held);
		r.iq    = cur_t'(iq_held);
		r.angle = angle_held;
		return r;
	endfunction

	function automatic cur_t rand_current();
		int v;
		case ($urandom_range(0, 4))
			1: begin
				v = $urandom_range(0, 40);
				v = v - 20;
			end
			2: v = $urandom_range(0, 1) ? 32767 : -32768;
			3: v = 0;
			default: v = $urandom;
		endcase
		return cur_t'(v);
	endfunction

	task automatic queue_tick(logic req, cur_t id, cur_t iq, logic [ANGLE_W-1:0] angle);
		ramp_tick_t t;
		t.req   = req;
		t.id    = id;
		t.iq    = iq;
		t.angle = angle;
		tick_pending.push_back(t);
		ticks_in_flight++;
	endtask

	task automatic queue_request_run(int len);
		repeat (len)
			queue_tick(1'b1, rand_current(), rand_current(), ANGLE_W'($urandom));
	endtask

	// Mostly a pass-through word followed by a run of ramp requests,
	// sometimes a lone word with a random request bit.
	task automatic queue_random_phase(int n_items, int ticks);
		int made;
		int run_len;
		made = 0;
		while (made < n_items) begin
			if ($urandom_range(0, 99) < 85) begin
				queue_tick(1'b0, rand_current(), rand_current(), ANGLE_W'($urandom));
				run_len = $urandom_range(0, (ticks <= GAP_MAX) ? 2 * ticks + 6 : 40);
				queue_request_run(run_len);
				made += run_len + 1;
			end else begin
				queue_tick(1'($urandom), rand_current(), rand_current(), ANGLE_W'($urandom));
				made++;
			end
		end
	endtask

	// Wait for every word to come back, then let the divider finish.
	task automatic drain();
		while (ticks_in_flight != 0 || dq_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_ramp_ticks(logic [TICK_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid      <= 1'b0;
		ramp_ticks_cfg = v;
		drv_burst      = ($urandom_range(0, 3) == 0);
		mon_burst      = ($urandom_range(0, 3) == 0);
	endtask

	// driver
	ramp_tick_t drv_tick;
	int         gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				dq_expected.push_back(ramp_predict(drv_tick));
				ticks_in_flight--;
				gap_left = drv_burst ? 0 : $urandom_range(0, GAP_MAX);
			end
			// hold a stalled word as it is
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (tick_pending.size() > 0) begin
					drv_tick = tick_pending.pop_front();
					in_valid      <= 1'b1;
					start_request <= drv_tick.req;
					id_ref_in     <= drv_tick.id;
					iq_ref_in     <= drv_tick.iq;
					angle_in      <= drv_tick.angle;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	dq_ref_t want;
	int      stall_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (dq_expected.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected word: id=%0d iq=%0d angle=%0d",
							id_ref_out, iq_ref_out, angle_out);
				end else begin
					want = dq_expected.pop_front();
					if (id_ref_out !== want.id || iq_ref_out !== want.iq
							|| angle_out !== want.angle) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display({"mismatch: exp id=%0d iq=%0d angle=%0d, ",
								"got id=%0d iq=%0d angle=%0d"},
								want.id, want.iq, want.angle,
								id_ref_out, iq_ref_out, angle_out);
					end
				end
				stall_left = mon_burst ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: any accepted word resets the count
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [TICK_W-1:0] ticks_list[6];
		int                k;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// ramp count zero acts as one: each request clears an axis at once
		set_ramp_ticks('0);
		queue_tick(1'b1, 16'sd1234, -16'sd77, 16'h1234);
		queue_tick(1'b0, 16'sd32767, -16'sd32768, 16'hFFFF);
		queue_tick(1'b1, 16'sd5, 16'sd5, 16'h0000);
		queue_tick(1'b1, 16'sd5, 16'sd5, 16'h0000);
		queue_tick(1'b0, -16'sd32768, 16'sd32767, 16'h0000);
		queue_tick(1'b1, 16'sd0, 16'sd0, 16'hFFFF);
		queue_tick(1'b1, 16'sd0, 16'sd0, 16'hFFFF);
		drain();

		// largest count: steps truncate to zero and become one LSB
		set_ramp_ticks('1);
		queue_tick(1'b0, 16'sd3, -16'sd2, 16'h5555);
		queue_request_run(6);
		queue_tick(1'b0, 16'sd0, 16'sd0, 16'hAAAA);
		queue_request_run(1);
		queue_tick(1'b0, -16'sd32768, 16'sd32767, 16'h8001);
		queue_request_run(1);
		drain();

		// negative d current ramps up toward zero
		set_ramp_ticks(TICK_W'(2));
		queue_tick(1'b0, -16'sd101, 16'sd51, 16'h7FFE);
		queue_request_run(6);
		drain();

		ticks_list[0] = TICK_W'(1);
		ticks_list[1] = TICK_W'($urandom_range(2, GAP_MAX));
		ticks_list[2] = RAMP_TICKS_RST;
		ticks_list[3] = '1;
		ticks_list[4] = TICK_W'($urandom);
		ticks_list[5] = '0;
		for (k = 0; k < 6; k++) begin
			set_ramp_ticks(ticks_list[k]);
			queue_random_phase(PHASE_ITEMS, int'(ticks_list[k]));
			drain();
		end

		if (fail_cnt == 0 && dq_expected.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
